// File: hdl/msk_pkg.sv
// Shared types, widths and codes for the min tracking stack.
package msk_pkg;

  localparam int VALUE_W = 32;
  localparam int FUNC_W = 2;
  localparam int ENTRY_W = 11;
  localparam int STATUS_W = 2;
  localparam int MSK_STACK_DEPTH = 1024;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  localparam value_t INT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  localparam func_t FUNC_PUSH = 2'd0;
  localparam func_t FUNC_POP = 2'd1;
  localparam func_t FUNC_READ = 2'd2;

  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // Shift commands broadcast to every cell of the row.
  typedef struct packed {
    logic val_push;
    logic val_pop;
    logic min_push;
    logic min_pop;
  } cell_ctrl_t;

endpackage

// File: hdl/msk_in_if.sv
// Operation channel: valid, ready and one operation beat.
interface msk_in_if;
  import msk_pkg::*;

  logic valid;
  logic ready;
  func_t func;
  value_t push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink (input valid, input func, input push_value, output ready);
endinterface

// File: hdl/msk_out_if.sv
// Result channel: valid, ready and one result beat.
interface msk_out_if;
  import msk_pkg::*;

  logic valid;
  logic ready;
  value_t top_value;
  value_t min_value;
  entry_t entry_count;
  status_t status;

  modport source (output valid, output top_value, output min_value,
                  output entry_count, output status, input ready);
  modport sink (input valid, input top_value, input min_value,
                input entry_count, input status, output ready);
endinterface

// File: hdl/msk_cell.sv
// One stack position: a value entry and a minimum entry that shift with neighbors.
module msk_cell (
  input  logic                clk,
  input  msk_pkg::cell_ctrl_t ctrl,
  input  msk_pkg::value_t     val_above,
  input  msk_pkg::value_t     val_below,
  input  msk_pkg::value_t     min_above,
  input  msk_pkg::value_t     min_below,
  output msk_pkg::value_t     val_q,
  output msk_pkg::value_t     min_q
);
  import msk_pkg::*;

  value_t val_r;
  value_t min_r;

  // A push moves every entry one place deeper; a pop moves it one place up.
  always_ff @(posedge clk) begin
    if (ctrl.val_push) begin
      val_r <= val_above;
    end else if (ctrl.val_pop) begin
      val_r <= val_below;
    end
    if (ctrl.min_push) begin
      min_r <= min_above;
    end else if (ctrl.min_pop) begin
      min_r <= min_below;
    end
  end

  assign val_q = val_r;
  assign min_q = min_r;

endmodule

// File: hdl/min_tracking_stack_core.sv
// Min tracking stack: LIFO of signed values that reports its running minimum.
//
// The block takes one operation beat on in_beat (push, pop or read) and
// returns one result beat on out_beat: the top value (0 when empty), the
// minimum (the largest signed value when empty), the entry count and a
// status. A push to a full stack is dropped with a full status; a pop of an
// empty stack is ignored with an empty status; an unused code acts as a read.
// The stack is a row of STACK_DEPTH cells. Cell 0 is always the top, so
// every push or pop that changes the stack is one shift of the whole row.
// The result is registered, so its beat follows in the cycle after the
// operation is accepted. One operation completes per cycle as long as
// results are taken; the rate is set by the result register, which must
// be free or emptied in the same cycle before the next operation is taken.
// When the receiver stalls, the result is held and in_beat.ready stays low
// until the result is taken. Reset clears the entry and minimum counts and
// the result valid; cell contents are left as they are and are never read
// before being written.
module min_tracking_stack_core #(
  parameter int STACK_DEPTH = msk_pkg::MSK_STACK_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  msk_in_if.sink         in_beat,
  msk_out_if.source      out_beat
);
  import msk_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] mcnt_r, mcnt_nxt;

  logic             out_valid_r;
  value_t           top_r, top_nxt;
  value_t           min_r, min_nxt;
  entry_t           count_r, count_nxt;
  status_t          status_r, status_nxt;

  cell_ctrl_t       cmd;
  cell_ctrl_t       cell_cmd;
  logic             take;
  value_t           cur_min;
  value_t           head_val_nxt;
  value_t           head_min_nxt;
  logic [CNT_W+ENTRY_W-1:0] count_ext;

  // Index STACK_DEPTH is a constant bottom so every cell has a lower neighbor.
  value_t val_q [STACK_DEPTH+1];
  value_t min_q [STACK_DEPTH+1];

  assign val_q[STACK_DEPTH] = '0;
  assign min_q[STACK_DEPTH] = '0;

  assign in_beat.ready = !out_valid_r || out_beat.ready;
  assign take = in_beat.valid && in_beat.ready;
  assign cell_cmd = take ? cmd : '0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      msk_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_cmd),
        .val_above (in_beat.push_value),
        .val_below (val_q[1]),
        .min_above (in_beat.push_value),
        .min_below (min_q[1]),
        .val_q     (val_q[0]),
        .min_q     (min_q[0])
      );
    end else begin : g_body
      msk_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_cmd),
        .val_above (val_q[i-1]),
        .val_below (val_q[i+1]),
        .min_above (min_q[i-1]),
        .min_below (min_q[i+1]),
        .val_q     (val_q[i]),
        .min_q     (min_q[i])
      );
    end
  end

  assign cur_min = (mcnt_r != '0) ? min_q[0] : INT_MAX;

  always_comb begin
    cmd = '0;
    status_nxt = ST_OK;
    cnt_nxt = cnt_r;
    mcnt_nxt = mcnt_r;
    case (in_beat.func)
      FUNC_PUSH: begin
        if (cnt_r == CNT_W'(STACK_DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.val_push = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (in_beat.push_value <= cur_min) begin
            cmd.min_push = 1'b1;
            mcnt_nxt = mcnt_r + CNT_W'(1);
          end
        end
      end
      FUNC_POP: begin
        if (cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd.val_pop = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (val_q[0] == cur_min && mcnt_r != '0) begin
            cmd.min_pop = 1'b1;
            mcnt_nxt = mcnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // What cell 0 will hold after this operation.
  always_comb begin
    if (cmd.val_push) begin
      head_val_nxt = in_beat.push_value;
    end else if (cmd.val_pop) begin
      head_val_nxt = val_q[1];
    end else begin
      head_val_nxt = val_q[0];
    end
    if (cmd.min_push) begin
      head_min_nxt = in_beat.push_value;
    end else if (cmd.min_pop) begin
      head_min_nxt = min_q[1];
    end else begin
      head_min_nxt = min_q[0];
    end
  end

  assign top_nxt = (cnt_nxt != '0) ? head_val_nxt : '0;
  assign min_nxt = (mcnt_nxt != '0) ? head_min_nxt : INT_MAX;
  assign count_ext = {{ENTRY_W{1'b0}}, cnt_nxt};
  assign count_nxt = count_ext[ENTRY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      mcnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        cnt_r <= cnt_nxt;
        mcnt_r <= mcnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      top_r <= top_nxt;
      min_r <= min_nxt;
      count_r <= count_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_beat.valid = out_valid_r;
  assign out_beat.top_value = top_r;
  assign out_beat.min_value = min_r;
  assign out_beat.entry_count = count_r;
  assign out_beat.status = status_r;

endmodule

// File: dv/min_tracking_stack_core_test.sv
// Testbench for the min tracking stack core: directed and random operations against a predictor.
`timescale 1ns / 100ps

module min_tracking_stack_core_test;
  import msk_pkg::*;

  localparam int DEPTH = MSK_STACK_DEPTH;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam func_t FUNC_UNUSED = 2'd3;
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct {
    value_t top;
    value_t min;
    entry_t count;
    status_t status;
  } stack_result_t;

  logic clk;
  logic rst_n;

  msk_in_if in_if ();
  msk_out_if out_if ();

  min_tracking_stack_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_if),
    .out_beat (out_if)
  );

  // Shadow copy of the stack and its minimum history.
  value_t held_values [DEPTH];
  value_t min_values [DEPTH];
  int held_count;
  int min_depth;
  value_t min_now;

  stack_result_t expected_results [$];
  int fail_count;
  bit steady;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic stack_result_t apply_stack_op(func_t f, value_t v);
    stack_result_t r;
    r.status = ST_OK;
    if (f == FUNC_PUSH) begin
      if (held_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        held_values[held_count] = v;
        held_count++;
        if (v <= min_now) begin
          if (min_depth < DEPTH) begin
            min_values[min_depth] = v;
            min_depth++;
          end
          min_now = v;
        end
      end
    end else if (f == FUNC_POP) begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        if (held_values[held_count-1] == min_now) begin
          if (min_depth > 0) min_depth--;
          min_now = (min_depth == 0) ? INT_MAX : min_values[min_depth-1];
        end
        held_count--;
      end
    end
    r.top = (held_count > 0) ? held_values[held_count-1] : '0;
    r.min = min_now;
    r.count = entry_t'(held_count);
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Biased toward extremes, the current minimum and values just below it.
  function automatic value_t rand_value();
    case ($urandom_range(0, 9))
      0: return VALUE_MIN;
      1: return INT_MAX;
      2: return min_now;
      3: return (min_now > VALUE_MIN + 8) ?
                min_now - value_t'($urandom_range(1, 8)) : min_now;
      4, 5: return value_t'($urandom_range(0, 40)) - 20;
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic send_op(func_t f, value_t v);
    int gap;
    in_if.valid <= 1'b1;
    in_if.func <= f;
    in_if.push_value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_results.push_back(apply_stack_op(f, v));
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_stack();
    send_op(FUNC_READ, value_t'($urandom));
    send_op(FUNC_POP, '1);
    send_op(FUNC_UNUSED, '1);
    send_op(FUNC_POP, '0);
    send_op(FUNC_PUSH, 7);
    send_op(FUNC_UNUSED, '0);
    send_op(FUNC_POP, '0);
  endtask

  task automatic test_extreme_values();
    send_op(FUNC_PUSH, INT_MAX);
    send_op(FUNC_PUSH, INT_MAX);
    send_op(FUNC_PUSH, 5);
    send_op(FUNC_PUSH, VALUE_MIN);
    send_op(FUNC_PUSH, VALUE_MIN);
    send_op(FUNC_PUSH, -1);
    send_op(FUNC_READ, '1);
    send_op(FUNC_POP, '1);
    // Duplicate minimum: the first pop keeps it, the second restores the previous minimum of 5.
    send_op(FUNC_POP, '0);
    send_op(FUNC_POP, '0);
    send_op(FUNC_POP, '0);
    send_op(FUNC_PUSH, VALUE_MIN + 1);
    send_op(FUNC_POP, '0);
    send_op(FUNC_POP, '0);
    send_op(FUNC_POP, '0);
    send_op(FUNC_POP, '1);
    wait_drain();
  endtask

  task automatic test_random_ops(int n_ops);
    int push_pct;
    int r;
    func_t f;
    push_pct = 50;
    for (int i = 0; i < n_ops; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 75;
        endcase
        steady = ($urandom_range(0, 3) == 0);
      end
      // The sender pauses once until every result is back.
      if (i == n_ops / 2) wait_drain();
      r = $urandom_range(0, 99);
      if (r < push_pct) f = FUNC_PUSH;
      else if (r < 94) f = FUNC_POP;
      else if (r < 98) f = FUNC_READ;
      else f = FUNC_UNUSED;
      send_op(f, (f == FUNC_PUSH) ? rand_value() : value_t'($urandom));
    end
    steady = 1'b0;
    wait_drain();
  endtask

  task automatic test_fill_overflow();
    int n;
    n = 0;
    while (held_count < DEPTH) begin
      // Stall the receiver for a long stretch while pushes keep coming.
      if (n == 40) hold_req = 1'b1;
      send_op(FUNC_PUSH, rand_value());
      n++;
    end
    send_op(FUNC_PUSH, VALUE_MIN);
    send_op(FUNC_PUSH, rand_value());
    send_op(FUNC_READ, '0);
    send_op(FUNC_UNUSED, '1);
    repeat (4) send_op(FUNC_POP, value_t'($urandom));
    repeat (6) send_op(FUNC_PUSH, rand_value());
    send_op(FUNC_READ, '1);
    wait_drain();
  endtask

  // Result side: random stalls plus one long hold-off on request.
  initial begin
    int gap;
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_if.ready <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          hold_left = gap - 1;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: top %0d min %0d count %0d status %0d",
                   out_if.top_value, out_if.min_value, out_if.entry_count, out_if.status);
      end else begin
        want = expected_results.pop_front();
        if (out_if.top_value !== want.top || out_if.min_value !== want.min ||
            out_if.entry_count !== want.count || out_if.status !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected top %0d min %0d count %0d status %0d,",
                     want.top, want.min, want.count, want.status,
                     " got top %0d min %0d count %0d status %0d",
                     out_if.top_value, out_if.min_value, out_if.entry_count,
                     out_if.status);
        end
      end
    end
  end

  // Ends the run when neither channel moves a beat for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.func = FUNC_READ;
    in_if.push_value = '0;
    held_count = 0;
    min_depth = 0;
    min_now = INT_MAX;
    fail_count = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_extreme_values();
    test_random_ops(500);
    test_fill_overflow();

    wait_drain();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
